### rtl/core/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UTF8SD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// Next-cycle implication, checked outside reset.
`define UTF8SD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

### rtl/core/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

  localparam int unsigned CpWidth   = 31;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned LeftWidth = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_END      = 2'd2
  } status_t;

  // Lead byte classification.
  typedef struct packed {
    logic                 is_ascii;
    logic                 invalid;
    logic [LeftWidth-1:0] left;
    logic [4:0]           pay;
  } lead_t;

  // One step's result.
  typedef struct packed {
    logic               emit;
    logic [CpWidth-1:0] cp;
    status_t            st;
  } result_t;

endpackage

### rtl/core/utf8sd_lead_dec.sv
// Lead byte decoder: continuation byte count and payload bits.
module utf8sd_lead_dec
  import utf8sd_pkg::*;
(
  input  logic [ByteWidth-1:0] lead,
  output lead_t                info
);

  always_comb begin
    info = '0;
    if (!lead[7]) begin
      info.is_ascii = 1'b1;
    end else if (lead[6:5] == 2'b10) begin
      info.left = 3'd1;
      info.pay  = lead[4:0];
    end else if (lead[6:4] == 3'b110) begin
      info.left = 3'd2;
      info.pay  = {1'b0, lead[3:0]};
    end else if (lead[6:3] == 4'b1110) begin
      info.left = 3'd3;
      info.pay  = {2'b00, lead[2:0]};
    end else if (lead[6:2] == 5'b11110) begin
      info.left = 3'd4;
      info.pay  = {3'b000, lead[1:0]};
    end else if (lead[6:1] == 6'b111110) begin
      info.left = 3'd5;
      info.pay  = {4'b0000, lead[0]};
    end else begin
      // 10xxxxxx, 0xFE and 0xFF
      info.invalid = 1'b1;
    end
  end

endmodule

### rtl/core/utf8sd_core.sv
// Decoder state and single-step update.
module utf8sd_core
  import utf8sd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [ByteWidth-1:0] data,
  input  logic                 eoi,
  output result_t              res
);

  logic [CpWidth-1:0]   accumulator;
  logic [CpWidth-1:0]   accumulator_next;
  logic [LeftWidth-1:0] bytes_left;
  logic [LeftWidth-1:0] bytes_left_next;
  logic [CpWidth-1:0]   shifted;
  lead_t                lead;

  utf8sd_lead_dec u_lead (
    .lead (data),
    .info (lead)
  );

  assign shifted = {accumulator[CpWidth-7:0], data[5:0]};

  always_comb begin
    accumulator_next = accumulator;
    bytes_left_next  = bytes_left;
    res              = '{emit: 1'b0, cp: '0, st: ST_OK};
    if (eoi) begin
      accumulator_next = '0;
      bytes_left_next  = '0;
      res              = '{emit: 1'b1, cp: '0, st: ST_END};
    end else if (bytes_left != '0) begin
      bytes_left_next = bytes_left - 3'd1;
      if (bytes_left == 3'd1) begin
        accumulator_next = '0;
        res              = '{emit: 1'b1, cp: shifted, st: ST_OK};
      end else begin
        accumulator_next = shifted;
      end
    end else if (lead.is_ascii) begin
      res = '{emit: 1'b1, cp: {{(CpWidth-7){1'b0}}, data[6:0]}, st: ST_OK};
    end else if (lead.invalid) begin
      accumulator_next = '0;
      bytes_left_next  = '0;
      res              = '{emit: 1'b1, cp: '0, st: ST_BAD_LEAD};
    end else begin
      accumulator_next = {{(CpWidth-5){1'b0}}, lead.pay};
      bytes_left_next  = lead.left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      bytes_left  <= '0;
    end else if (step) begin
      accumulator <= accumulator_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

### rtl/core/utf8_stream_decoder.sv
// Path: input register, one decode step, output register; out_stall can hold a byte.
// Throughput: one byte per cycle while out_stall does not hold the output register.
// in_stall rises only while the output register holds an untaken result.
// Reset (rst, synchronous, active high) clears the partial sequence and both valids.
// Top level of the UTF-8 stream decoder.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ByteWidth-1:0] byte_in,
  input  logic                 end_of_input,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CpWidth-1:0]   code_point,
  output logic [1:0]           status
);

  logic                 s1_valid;
  logic [ByteWidth-1:0] s1_byte;
  logic                 s1_eoi;
  logic                 fire;
  logic                 take;
  result_t              res;
  status_t              status_r;

  // Step the decoder when the output register is free or being drained.
  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_byte <= byte_in;
      s1_eoi  <= end_of_input;
    end
  end

  utf8sd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (fire),
    .data (s1_byte),
    .eoi  (s1_eoi),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      code_point <= res.cp;
      status_r   <= res.st;
    end
  end

  assign status = status_r;

  `UTF8SD_ASSERT_NOW(a_err_cp_zero, out_valid && (status_r != ST_OK), code_point == '0)
  `UTF8SD_ASSERT_NEXT(a_eoi_result, fire && s1_eoi, out_valid && (status_r == ST_END))
  `UTF8SD_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)

endmodule
